>>> src/ccrc_pkg.sv
// Package for the chunked CRC-32 checksum engine.
// Holds widths, register indexes, beat structs and the byte-wise CRC update.
// No dependencies.
package ccrc_pkg;

    // Chunk length after the optional leading chunk
    localparam int CHUNK_SIZE = 512;

    // Leading chunk length register width
    localparam int FLEN_W = 10;
    localparam int FLEN_MAX = (1 << FLEN_W) - 1;

    // Byte counter covers the longest possible chunk
    localparam int CNT_MAX = (CHUNK_SIZE > FLEN_MAX) ? CHUNK_SIZE : FLEN_MAX;
    localparam int CNT_W = $clog2(CNT_MAX + 1);
    localparam logic [CNT_W-1:0] CHUNK_LIMIT = CNT_W'(CHUNK_SIZE);

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = FLEN_W;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN = 2'd1;

    // Reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] expected_crc;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] chunk_crc;
        logic        chunk_match;
        logic        all_match;
        logic        length_error;
        logic        buffer_done;
    } t_result;

    typedef struct packed {
        logic                  vld;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // One byte through the reflected CRC, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/ccrc_in_reg.sv
// Input register stage of the chunked CRC-32 engine.
// Holds one accepted beat until the core consumes it. Uses ccrc_pkg.
module ccrc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ccrc_pkg::t_in_beat i_beat,
    output logic              o_valid,
    output ccrc_pkg::t_in_beat o_beat,
    input  logic              i_take
);
    import ccrc_pkg::*;

    logic     r_vld;
    t_in_beat r_beat;

    // Free when empty or when the held beat moves on this cycle
    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

>>> src/ccrc_core.sv
// Chunk tracking, CRC update, check logic and result register.
// Holds configuration registers and per-buffer state. Uses ccrc_pkg.
module ccrc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccrc_pkg::t_cfg_wr  i_cfg,
    input  logic               i_valid,
    input  ccrc_pkg::t_in_beat i_beat,
    output logic               o_take,
    output logic               o_res_valid,
    output ccrc_pkg::t_result  o_res,
    input  logic               i_res_ready
);
    import ccrc_pkg::*;

    // Configuration
    logic              r_check_mode;
    logic [FLEN_W-1:0] r_first_len;

    // Buffer state
    logic [31:0]      r_crc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_in_first;
    logic             r_pass;
    logic             r_mid;

    // Result register
    logic    r_res_vld;
    t_result r_res;

    logic [31:0]      n_crc;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_first_lim;
    logic [CNT_W-1:0] w_limit;
    logic             w_closes;
    logic             w_short;
    logic             w_match;
    logic             w_pass;

    // Per-byte datapath
    always_comb begin
        w_first_lim = CNT_W'(r_first_len);
        w_limit     = r_in_first ? w_first_lim : CHUNK_LIMIT;
        n_crc       = crc_byte(r_crc, i_beat.data_byte);
        n_cnt       = r_cnt + CNT_W'(1);
        w_closes    = (n_cnt >= w_limit) || i_beat.last_byte;
        w_short     = i_beat.last_byte && r_in_first && (n_cnt < w_first_lim);
        if (w_short) begin
            w_match = 1'b0;
        end else begin
            w_match = r_check_mode ? (n_crc == i_beat.expected_crc) : 1'b1;
        end
        w_pass = r_pass && w_match;
    end

    // A beat that closes a chunk needs room in the result register
    assign o_take = i_valid && (!w_closes || !r_res_vld || i_res_ready);

    // Configuration writes and buffer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
            r_first_len  <= '0;
            r_crc        <= '0;
            r_cnt        <= '0;
            r_in_first   <= 1'b0;
            r_pass       <= 1'b1;
            r_mid        <= 1'b0;
        end else begin
            if (i_cfg.vld) begin
                case (i_cfg.idx)
                    REG_CHECK_MODE: r_check_mode <= i_cfg.data[0];
                    REG_FIRST_LEN: begin
                        r_first_len <= i_cfg.data;
                        if (!r_mid) begin
                            r_in_first <= (i_cfg.data != '0);
                        end
                    end
                    default: ;
                endcase
            end
            if (o_take) begin
                if (!w_closes) begin
                    r_crc <= n_crc;
                    r_cnt <= n_cnt;
                    r_mid <= 1'b1;
                end else if (i_beat.last_byte) begin
                    r_crc      <= '0;
                    r_cnt      <= '0;
                    r_in_first <= (r_first_len != '0);
                    r_pass     <= 1'b1;
                    r_mid      <= 1'b0;
                end else begin
                    r_crc      <= '0;
                    r_cnt      <= '0;
                    r_in_first <= 1'b0;
                    r_pass     <= w_pass;
                    r_mid      <= 1'b1;
                end
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (o_take && w_closes) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take && w_closes) begin
            r_res.chunk_crc    <= n_crc;
            r_res.chunk_match  <= w_match;
            r_res.all_match    <= w_pass;
            r_res.length_error <= w_short;
            r_res.buffer_done  <= i_beat.last_byte;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

>>> src/chunked_crc32_checksum_engine.sv
// Top level of the chunked CRC-32 checksum engine.
// Instantiates ccrc_in_reg and ccrc_core. Uses ccrc_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready   | i_data_byte, i_last_byte, i_expected_crc
//  out     | out       | o_out_valid / i_out_ready | o_chunk_crc .. o_buffer_done
//
// One byte per cycle sustained while no chunk-closing beat waits on a stalled result;
// a beat is held in the input register, then the CRC update and chunk close decision
// write the result register.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the input register only when the next beat closes a chunk.
module chunked_crc32_checksum_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    input  logic [31:0]                         i_expected_crc,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [31:0]                         o_chunk_crc,
    output logic                                o_chunk_match,
    output logic                                o_all_match,
    output logic                                o_length_error,
    output logic                                o_buffer_done
);
    import ccrc_pkg::*;

    t_in_beat w_in_beat;
    t_in_beat w_s1_beat;
    t_cfg_wr  w_cfg;
    t_result  w_res;
    logic     w_s1_vld;
    logic     w_take;

    // Pack input beat and config write
    assign w_in_beat = '{data_byte: i_data_byte, last_byte: i_last_byte,
                         expected_crc: i_expected_crc};
    assign o_cfg_ready = 1'b1;
    assign w_cfg = '{vld: i_cfg_valid, idx: i_cfg_index, data: i_cfg_data};

    ccrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (w_in_beat),
        .o_valid (w_s1_vld),
        .o_beat  (w_s1_beat),
        .i_take  (w_take)
    );

    ccrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_s1_vld),
        .i_beat      (w_s1_beat),
        .o_take      (w_take),
        .o_res_valid (o_out_valid),
        .o_res       (w_res),
        .i_res_ready (i_out_ready)
    );

    // Unpack result beat
    assign o_chunk_crc    = w_res.chunk_crc;
    assign o_chunk_match  = w_res.chunk_match;
    assign o_all_match    = w_res.all_match;
    assign o_length_error = w_res.length_error;
    assign o_buffer_done  = w_res.buffer_done;

endmodule

>>> src/ccrc_checker.sv
// Port-level checker for the chunked CRC-32 engine, bound to the top level.
// Sees only top-level ports. No package dependency.
module ccrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_chunk_crc,
    input logic        o_chunk_match,
    input logic        o_all_match,
    input logic        o_length_error,
    input logic        o_buffer_done
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_chunk_crc))
        else $error("result beat changed while stalled");

    // Length error only at buffer end, and it fails the chunk
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> o_buffer_done && !o_chunk_match)
        else $error("length error without buffer end or with match");

    // Sticky flag follows a failing chunk
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chunk_match |-> !o_all_match)
        else $error("all_match set after a failing chunk");

    // Short buffer never passes overall
    a_len_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> !o_all_match)
        else $error("all_match set on a short buffer");

endmodule

bind chunked_crc32_checksum_engine ccrc_checker u_ccrc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_chunk_crc    (o_chunk_crc),
    .o_chunk_match  (o_chunk_match),
    .o_all_match    (o_all_match),
    .o_length_error (o_length_error),
    .o_buffer_done  (o_buffer_done)
);
